/* hw/rtl/blbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_pkg
// Shared types and constants for the 1D blend bracket and weight split block.
// ----------------------------------------------------------------------------
package blbr_pkg;

   // Table geometry
   localparam int BLBR_TABLE_DEPTH = 16;
   localparam int POS_WIDTH        = 16;
   localparam int WEIGHT_WIDTH     = 16;
   localparam int COUNT_WIDTH      = 5;
   localparam int INDEX_WIDTH      = 4;
   localparam int ACTIVE_WIDTH     = 2;

   // Fraction is Q0.15, one quotient bit per divider step
   localparam int FRAC_BITS        = 15;
   localparam int DIV_STEP_WIDTH   = $clog2(FRAC_BITS);
   localparam int PROD_WIDTH       = WEIGHT_WIDTH + FRAC_BITS;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE   = 16'h8000;
   localparam logic [PROD_WIDTH:0]     ROUND_HALF   = (PROD_WIDTH + 1)'(1 << (FRAC_BITS - 1));

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Active entry counts
   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_NONE   = 2'd0;
   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_SINGLE = 2'd1;
   localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_PAIR   = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DIVIDE,
      ST_MULT,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // write one table entry
      logic start;     // capture an evaluate item
      logic scan;      // issue table reads
      logic div_init;  // set up the fraction divide
      logic div_step;  // one restoring divide step
      logic mult;      // weight times fraction
      logic out_load;  // fill the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic pair;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

/* hw/rtl/blbr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module blbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/blbr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_ctrl
// Controller: sequences load, scan, divide, multiply and result hand-off.
// ----------------------------------------------------------------------------
module blbr_ctrl
   import blbr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     req_stall
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_operation == OP_EVAL)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.pair ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load  = req_valid && (req_operation == OP_LOAD);
            cmd.start = req_valid && (req_operation == OP_EVAL);
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_CHECK: begin
            cmd.div_init = stat.pair;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/blbr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_datapath
// Position table, bracket search registers, restoring divider, weight
// multiplier and the result register.
// ----------------------------------------------------------------------------
module blbr_datapath
   import blbr_pkg::*;
#(
   parameter int TABLE_DEPTH = BLBR_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output stat_type                       stat,
   // input item
   input  logic [INDEX_WIDTH-1:0]         req_entry_index,
   input  logic signed [POS_WIDTH-1:0]    req_position,
   input  logic signed [POS_WIDTH-1:0]    req_blend_parameter,
   input  logic [WEIGHT_WIDTH-1:0]        req_overall_weight,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [COUNT_WIDTH-1:0]         csr_write_data,
   // result item
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_status,
   output logic [ACTIVE_WIDTH-1:0]        rsp_active_count,
   output logic [INDEX_WIDTH-1:0]         rsp_first_index,
   output logic [INDEX_WIDTH-1:0]         rsp_second_index,
   output logic [WEIGHT_WIDTH-1:0]        rsp_first_weight,
   output logic [WEIGHT_WIDTH-1:0]        rsp_second_weight
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
   localparam int LW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

   // ---------------------------------------------------------------- config
   logic [COUNT_WIDTH-1:0] entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_WIDTH'(1);
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------- table
   logic                        wr_en;
   logic                        rd_en;
   logic signed [POS_WIDTH-1:0] rd_pos;
   logic [CW-1:0]               scan_cnt_ff;
   logic [CW-1:0]               scan_cnt_in;
   logic [CW-1:0]               n_ff;

   // loads to entries beyond the table are dropped
   assign wr_en = cmd.load && (LW'(req_entry_index) < LW'(TABLE_DEPTH));
   assign rd_en = cmd.scan && (scan_cnt_ff < n_ff);

   blbr_ram #(
      .WIDTH (POS_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_position),
      .rd_en   (rd_en),
      .rd_addr (scan_cnt_ff[AW-1:0]),
      .rd_data (rd_pos)
   );

   // ---------------------------------------------------------------- item capture
   logic signed [POS_WIDTH-1:0] param_ff;
   logic [WEIGHT_WIDTH-1:0]     weight_ff;
   logic [CW-1:0]               n_in;
   logic [MW-1:0]               count_ext;

   assign count_ext = MW'(entry_count_ff);
   assign n_in      = (count_ext > MW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ext);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         param_ff  <= req_blend_parameter;
         weight_ff <= (req_overall_weight > WEIGHT_ONE) ? WEIGHT_ONE : req_overall_weight;
         n_ff      <= n_in;
      end
   end

   // ---------------------------------------------------------------- scan
   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (cmd.start) begin
         scan_cnt_in = '0;
      end else if (rd_en) begin
         scan_cnt_in = scan_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= scan_cnt_ff[AW-1:0];
   end

   // Bracket registers; strict compares keep the first of equal positions
   logic                        have_lo_ff;
   logic                        have_hi_ff;
   logic signed [POS_WIDTH-1:0] lo_pos_ff;
   logic signed [POS_WIDTH-1:0] hi_pos_ff;
   logic [AW-1:0]               lo_idx_ff;
   logic [AW-1:0]               hi_idx_ff;
   logic                        lo_take;
   logic                        hi_take;

   assign lo_take = rd_vld_ff && (rd_pos <= param_ff) && (!have_lo_ff || (rd_pos > lo_pos_ff));
   assign hi_take = rd_vld_ff && (rd_pos >= param_ff) && (!have_hi_ff || (rd_pos < hi_pos_ff));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         have_lo_ff <= 1'b0;
         have_hi_ff <= 1'b0;
      end else begin
         if (lo_take) begin
            have_lo_ff <= 1'b1;
            lo_pos_ff  <= rd_pos;
            lo_idx_ff  <= rd_idx_ff;
         end
         if (hi_take) begin
            have_hi_ff <= 1'b1;
            hi_pos_ff  <= rd_pos;
            hi_idx_ff  <= rd_idx_ff;
         end
      end
   end

   logic pair;

   // exact hit lands on the same entry from both sides
   assign pair = have_lo_ff && have_hi_ff && (lo_idx_ff != hi_idx_ff);

   // ---------------------------------------------------------------- divide
   // frac = floor((P - L) * 2^15 / (U - L)), with P - L < U - L
   logic [POS_WIDTH:0]         num_full;
   logic [POS_WIDTH:0]         dist_full;
   logic [POS_WIDTH-1:0]       dist_ff;
   logic [POS_WIDTH-1:0]       rem_ff;
   logic [FRAC_BITS-1:0]       quo_ff;
   logic [DIV_STEP_WIDTH-1:0]  step_ff;
   logic [POS_WIDTH:0]         rem_shift;
   logic                       rem_ge;

   assign num_full  = {param_ff[POS_WIDTH-1], param_ff} - {lo_pos_ff[POS_WIDTH-1], lo_pos_ff};
   assign dist_full = {hi_pos_ff[POS_WIDTH-1], hi_pos_ff} - {lo_pos_ff[POS_WIDTH-1], lo_pos_ff};
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, dist_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dist_ff <= dist_full[POS_WIDTH-1:0];
         rem_ff  <= num_full[POS_WIDTH-1:0];
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? POS_WIDTH'(rem_shift - {1'b0, dist_ff}) : rem_shift[POS_WIDTH-1:0];
         quo_ff  <= {quo_ff[FRAC_BITS-2:0], rem_ge};
         step_ff <= step_ff + DIV_STEP_WIDTH'(1);
      end
   end

   // ---------------------------------------------------------------- weight split
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [PROD_WIDTH:0]     prod_rnd;
   logic [WEIGHT_WIDTH:0]   w2_full;
   logic [WEIGHT_WIDTH-1:0] w2;

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= PROD_WIDTH'(weight_ff) * PROD_WIDTH'(quo_ff);
      end
   end

   // round half up, never above the overall weight
   assign prod_rnd = {1'b0, prod_ff} + ROUND_HALF;
   assign w2_full  = prod_rnd[PROD_WIDTH:FRAC_BITS];
   assign w2       = (w2_full > {1'b0, weight_ff}) ? weight_ff : w2_full[WEIGHT_WIDTH-1:0];

   // ---------------------------------------------------------------- result register
   logic                     rsp_valid_ff;
   logic                     rsp_status_ff;
   logic [ACTIVE_WIDTH-1:0]  rsp_active_count_ff;
   logic [INDEX_WIDTH-1:0]   rsp_first_index_ff;
   logic [INDEX_WIDTH-1:0]   rsp_second_index_ff;
   logic [WEIGHT_WIDTH-1:0]  rsp_first_weight_ff;
   logic [WEIGHT_WIDTH-1:0]  rsp_second_weight_ff;
   logic                     out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         priority if (pair) begin
            rsp_status_ff        <= STATUS_OK;
            rsp_active_count_ff  <= ACTIVE_PAIR;
            rsp_first_index_ff   <= INDEX_WIDTH'(lo_idx_ff);
            rsp_second_index_ff  <= INDEX_WIDTH'(hi_idx_ff);
            rsp_first_weight_ff  <= weight_ff - w2;
            rsp_second_weight_ff <= w2;
         end else if (have_lo_ff || have_hi_ff) begin
            rsp_status_ff        <= STATUS_OK;
            rsp_active_count_ff  <= ACTIVE_SINGLE;
            rsp_first_index_ff   <= have_lo_ff ? INDEX_WIDTH'(lo_idx_ff)
                                               : INDEX_WIDTH'(hi_idx_ff);
            rsp_second_index_ff  <= '0;
            rsp_first_weight_ff  <= weight_ff;
            rsp_second_weight_ff <= '0;
         end else begin
            rsp_status_ff        <= STATUS_ERR;
            rsp_active_count_ff  <= ACTIVE_NONE;
            rsp_first_index_ff   <= '0;
            rsp_second_index_ff  <= '0;
            rsp_first_weight_ff  <= '0;
            rsp_second_weight_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_active_count  = rsp_active_count_ff;
   assign rsp_first_index   = rsp_first_index_ff;
   assign rsp_second_index  = rsp_second_index_ff;
   assign rsp_first_weight  = rsp_first_weight_ff;
   assign rsp_second_weight = rsp_second_weight_ff;

   // ---------------------------------------------------------------- status
   assign stat.scan_done = (scan_cnt_ff == n_ff);
   assign stat.pair      = pair;
   assign stat.div_last  = (step_ff == DIV_STEP_WIDTH'(FRAC_BITS - 1));
   assign stat.out_free  = out_free;

endmodule

/* hw/rtl/blend_bracket_lerp_weights_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_bracket_lerp_weights_core
// 1D blend space: brackets a blend parameter between table positions and
// splits an overall weight between the lower and upper entries.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_stall   operation, entry_index, position,
//                                          blend_parameter, overall_weight
//   rsp_      out   rsp_valid / rsp_stall   status, active_count, first/second
//                                          index, first/second weight
//   csr_      in    csr_write_enable        csr_write_data (entry_count)
//
// A load item leaves req_stall low. An evaluate item over n active entries keeps
// req_stall high after its accept until its hand-off. When the parameter falls
// between two entries it runs a scan through the registered RAM read port, a
// check, 15 restoring divide steps, a multiply and the hand-off; otherwise it
// runs only the scan, the check and the hand-off.
// The hand-off waits while a stalled result still sits in the output register;
// that register holds it under rsp_stall while the next item is accepted.
// Reset is synchronous; table contents are not cleared by it.
//
module blend_bracket_lerp_weights_core
   import blbr_pkg::*;
#(
   parameter int TABLE_DEPTH = BLBR_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // input items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [INDEX_WIDTH-1:0]      req_entry_index,
   input  logic signed [POS_WIDTH-1:0] req_position,
   input  logic signed [POS_WIDTH-1:0] req_blend_parameter,
   input  logic [WEIGHT_WIDTH-1:0]     req_overall_weight,
   // result items
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_status,
   output logic [ACTIVE_WIDTH-1:0]     rsp_active_count,
   output logic [INDEX_WIDTH-1:0]      rsp_first_index,
   output logic [INDEX_WIDTH-1:0]      rsp_second_index,
   output logic [WEIGHT_WIDTH-1:0]     rsp_first_weight,
   output logic [WEIGHT_WIDTH-1:0]     rsp_second_weight,
   // configuration
   input  logic                        csr_write_enable,
   input  logic [COUNT_WIDTH-1:0]      csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   blbr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .req_stall     (req_stall)
   );

   blbr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_entry_index     (req_entry_index),
      .req_position        (req_position),
      .req_blend_parameter (req_blend_parameter),
      .req_overall_weight  (req_overall_weight),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_active_count    (rsp_active_count),
      .rsp_first_index     (rsp_first_index),
      .rsp_second_index    (rsp_second_index),
      .rsp_first_weight    (rsp_first_weight),
      .rsp_second_weight   (rsp_second_weight)
   );

endmodule

/* hw/rtl/blbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_checker
// Port-level checks on the blend bracket core, attached by bind.
// ----------------------------------------------------------------------------
module blbr_checker
   import blbr_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_operation,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_status,
   input logic [ACTIVE_WIDTH-1:0]     rsp_active_count,
   input logic [INDEX_WIDTH-1:0]      rsp_first_index,
   input logic [INDEX_WIDTH-1:0]      rsp_second_index,
   input logic [WEIGHT_WIDTH-1:0]     rsp_first_weight,
   input logic [WEIGHT_WIDTH-1:0]     rsp_second_weight
);

   // stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_active_count) && $stable(rsp_first_index)
         && $stable(rsp_second_index) && $stable(rsp_first_weight)
         && $stable(rsp_second_weight))
      else $error("stalled result item changed");

   // an accepted evaluate keeps the input side busy the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_EVAL) |=> req_stall)
      else $error("input accepted while evaluate in work");

   // error result carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ERR) |-> (rsp_active_count == ACTIVE_NONE)
         && (rsp_first_index == '0) && (rsp_second_index == '0)
         && (rsp_first_weight == '0) && (rsp_second_weight == '0))
      else $error("error result with nonzero fields");

   // single result has an empty second slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> ((rsp_active_count == ACTIVE_SINGLE)
         && (rsp_second_index == '0) && (rsp_second_weight == '0))
         || (rsp_active_count == ACTIVE_PAIR))
      else $error("bad result shape");

   // split weights never exceed one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_active_count == ACTIVE_PAIR) |->
         ({1'b0, rsp_first_weight} + {1'b0, rsp_second_weight}) <= {1'b0, WEIGHT_ONE})
      else $error("weight split above one");

endmodule

bind blend_bracket_lerp_weights_core blbr_checker u_blbr_checker (.*);
